FILE: rtl/crce_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crce_pkg: shared types and constants
// Types, codes and calendar helpers for the countdown reminder with clock
// editor.
// ---------------------------------------------------------------------------
package crce_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SETUP = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REQ_ENCODER = 2'd0,
    REQ_MAIN    = 2'd1,
    REQ_SETUP   = 2'd2,
    REQ_TICK    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_FLOOR   = 2'd0,
    CFG_CEILING = 2'd1,
    CFG_DETENT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FIELD_YEAR    = 3'd0,
    FIELD_MONTH   = 3'd1,
    FIELD_DAY     = 3'd2,
    FIELD_HOUR    = 3'd3,
    FIELD_MINUTE  = 3'd4,
    FIELD_SECOND  = 3'd5,
    FIELD_CONFIRM = 3'd6
  } field_t;

  typedef enum logic {
    SQ_READY  = 1'b0,
    SQ_DETENT = 1'b1
  } seq_t;

  typedef struct packed {
    field_t      field;
    logic        save;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } edit_t;

  localparam logic [11:0] YEAR_MIN      = 12'd2000;
  localparam logic [11:0] YEAR_MAX      = 12'd2099;
  localparam logic [11:0] YEAR_DEFAULT  = 12'd2025;
  localparam logic [3:0]  MONTH_MIN     = 4'd1;
  localparam logic [3:0]  MONTH_MAX     = 4'd12;
  localparam logic [4:0]  DAY_MIN       = 5'd1;
  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [5:0]  MINSEC_MAX    = 6'd59;
  localparam logic [7:0]  MINUTES_RESET = 8'd15;
  localparam logic [7:0]  FLOOR_RESET   = 8'd10;
  localparam logic [7:0]  CEILING_RESET = 8'd60;
  localparam logic [2:0]  DETENT_RESET  = 3'd2;

  // Years are kept within 2000..2099, where every fourth year is a leap year.
  function automatic logic [4:0] month_days(input logic [11:0] year,
                                            input logic [3:0] month);
    logic [4:0] d;
    case (month) inside
      4'd2:                     d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/countdown_reminder_with_clock_editor.sv
`default_nettype none
// ---------------------------------------------------------------------------
// countdown_reminder_with_clock_editor: reminder controller top level
// Four-mode controller (idle, clock setup, counting, alarm) driven by
// encoder, key and one-second tick events, with a calendar clock editor.
//
//   channel | direction | handshake          | contents
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_stall  | event type, encoder, time
//   out     | output    | out_valid/out_stall| mode, settings, edited time
//   cfg     | input     | cfg_we             | floor, ceiling, detent size
//
// Key and tick events finish in the cycle they are accepted. An encoder event
// is accepted, then applies its detents one at a time through the shared
// detent unit, and ends with a closing step.
// Reset is synchronous and restores the power-on state with no clearing pass.
// The result of a transaction is held until taken; no new transaction is
// accepted while the detent sequencer runs or a result is stalled.
// ---------------------------------------------------------------------------
module countdown_reminder_with_clock_editor
  import crce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic signed [6:0] encoder_change,
  input  logic              clock_valid,
  input  logic [11:0]       now_year,
  input  logic [3:0]        now_month,
  input  logic [4:0]        now_day,
  input  logic [4:0]        now_hour,
  input  logic [5:0]        now_minute,
  input  logic [5:0]        now_second,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        mode,
  output logic [7:0]        reminder_minutes,
  output logic [13:0]       seconds_left,
  output logic [2:0]        edit_field,
  output logic              choice_save,
  output logic [11:0]       edit_year,
  output logic [3:0]        edit_month,
  output logic [4:0]        edit_day,
  output logic [4:0]        edit_hour,
  output logic [5:0]        edit_minute,
  output logic [5:0]        edit_second,
  output logic              commit_time
);

  seq_t               seq, seq_next;
  mode_t              mode_reg, mode_next;
  logic [7:0]         minutes, minutes_next;
  logic [13:0]        countdown, countdown_next;
  logic signed [7:0]  residue, residue_next;
  edit_t              edit, edit_next;
  logic [7:0]         minutes_floor, minutes_ceiling;
  logic [2:0]         counts_per_detent;
  logic               out_valid_next;
  logic               commit, commit_next;

  logic               accept;
  logic               finish;
  logic [2:0]         step_size;
  logic signed [7:0]  step_ext;
  logic signed [7:0]  enc_ext;
  logic               det_pos;
  logic               det_neg;
  logic [7:0]         det_minutes;
  edit_t              det_edit;
  edit_t              load_edit;
  logic [11:0]        load_year;
  logic [3:0]         load_month;
  logic [4:0]         load_days;

  assign step_size = (counts_per_detent == 3'd0) ? 3'd1 : counts_per_detent;
  assign step_ext  = signed'({5'd0, step_size});
  assign enc_ext   = signed'({encoder_change[6], encoder_change});
  assign det_pos   = (residue >= step_ext);
  assign det_neg   = (residue <= -step_ext);
  assign in_stall  = (seq != SQ_READY) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;

  crce_detent u_detent (
    .mode            (mode_reg),
    .positive        (det_pos),
    .minutes         (minutes),
    .minutes_floor   (minutes_floor),
    .minutes_ceiling (minutes_ceiling),
    .edit_in         (edit),
    .minutes_next    (det_minutes),
    .edit_out        (det_edit)
  );

  // Current time saturated into range, or the default date when invalid.
  always_comb begin
    load_year  = (now_year < YEAR_MIN) ? YEAR_MIN :
                 ((now_year > YEAR_MAX) ? YEAR_MAX : now_year);
    load_month = (now_month < MONTH_MIN) ? MONTH_MIN :
                 ((now_month > MONTH_MAX) ? MONTH_MAX : now_month);
    load_days  = month_days(load_year, load_month);
    load_edit.field = FIELD_YEAR;
    load_edit.save  = 1'b1;
    if (clock_valid) begin
      load_edit.year   = load_year;
      load_edit.month  = load_month;
      load_edit.day    = (now_day < DAY_MIN) ? DAY_MIN :
                         ((now_day > load_days) ? load_days : now_day);
      load_edit.hour   = (now_hour > HOUR_MAX) ? HOUR_MAX : now_hour;
      load_edit.minute = (now_minute > MINSEC_MAX) ? MINSEC_MAX : now_minute;
      load_edit.second = (now_second > MINSEC_MAX) ? MINSEC_MAX : now_second;
    end else begin
      load_edit.year   = YEAR_DEFAULT;
      load_edit.month  = MONTH_MIN;
      load_edit.day    = DAY_MIN;
      load_edit.hour   = 5'd0;
      load_edit.minute = 6'd0;
      load_edit.second = 6'd0;
    end
  end

  always_comb begin
    seq_next       = seq;
    mode_next      = mode_reg;
    minutes_next   = minutes;
    countdown_next = countdown;
    residue_next   = residue;
    edit_next      = edit;
    commit_next    = commit;
    finish         = 1'b0;
    case (seq)
      SQ_READY: begin
        if (accept) begin
          case (req_type)
            REQ_ENCODER: begin
              residue_next = residue + enc_ext;
              seq_next     = SQ_DETENT;
            end
            REQ_MAIN: begin
              finish      = 1'b1;
              commit_next = 1'b0;
              if (mode_reg == MODE_SETUP) begin
                if (edit.field != FIELD_CONFIRM) begin
                  edit_next.field = field_t'(edit.field + 3'd1);
                end else begin
                  commit_next = edit.save;
                  mode_next   = MODE_IDLE;
                end
              end else if (mode_reg == MODE_IDLE) begin
                mode_next      = MODE_COUNT;
                countdown_next = {minutes, 6'd0} - {4'd0, minutes, 2'd0};
              end else begin
                mode_next      = MODE_IDLE;
                countdown_next = 14'd0;
              end
            end
            REQ_SETUP: begin
              finish      = 1'b1;
              commit_next = 1'b0;
              if (mode_reg == MODE_IDLE) begin
                mode_next = MODE_SETUP;
                edit_next = load_edit;
              end
            end
            default: begin
              finish      = 1'b1;
              commit_next = 1'b0;
              if (mode_reg == MODE_COUNT) begin
                if (countdown != 14'd0) countdown_next = countdown - 14'd1;
                else mode_next = MODE_ALARM;
              end
            end
          endcase
        end
      end
      SQ_DETENT: begin
        if (det_pos) begin
          minutes_next = det_minutes;
          edit_next    = det_edit;
          residue_next = residue - step_ext;
        end else if (det_neg) begin
          minutes_next = det_minutes;
          edit_next    = det_edit;
          residue_next = residue + step_ext;
        end else begin
          finish      = 1'b1;
          commit_next = 1'b0;
          seq_next    = SQ_READY;
        end
      end
      default: seq_next = SQ_READY;
    endcase
    out_valid_next = finish || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq               <= SQ_READY;
      mode_reg          <= MODE_IDLE;
      minutes           <= MINUTES_RESET;
      countdown         <= 14'd0;
      residue           <= 8'sd0;
      edit.field        <= FIELD_YEAR;
      edit.save         <= 1'b1;
      edit.year         <= YEAR_DEFAULT;
      edit.month        <= MONTH_MIN;
      edit.day          <= DAY_MIN;
      edit.hour         <= 5'd0;
      edit.minute       <= 6'd0;
      edit.second       <= 6'd0;
      out_valid         <= 1'b0;
      commit            <= 1'b0;
      minutes_floor     <= FLOOR_RESET;
      minutes_ceiling   <= CEILING_RESET;
      counts_per_detent <= DETENT_RESET;
    end else begin
      seq       <= seq_next;
      mode_reg  <= mode_next;
      minutes   <= minutes_next;
      countdown <= countdown_next;
      residue   <= residue_next;
      edit      <= edit_next;
      out_valid <= out_valid_next;
      commit    <= commit_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FLOOR:   minutes_floor     <= cfg_data;
          CFG_CEILING: minutes_ceiling   <= cfg_data;
          CFG_DETENT:  counts_per_detent <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  assign mode             = mode_reg;
  assign reminder_minutes = minutes;
  assign seconds_left     = countdown;
  assign edit_field       = edit.field;
  assign choice_save      = edit.save;
  assign edit_year        = edit.year;
  assign edit_month       = edit.month;
  assign edit_day         = edit.day;
  assign edit_hour        = edit.hour;
  assign edit_minute      = edit.minute;
  assign edit_second      = edit.second;
  assign commit_time      = commit;

  // The sequencer only runs while the result register is empty.
  a_detent_no_result: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_DETENT) |-> !out_valid)
    else $error("detent sequencer running while a result is pending");

  // A commit is only reported on the way back to idle.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    commit |-> (mode_reg == MODE_IDLE))
    else $error("commit reported outside idle mode");

  // The edited day never exceeds the length of the edited month.
  a_day_in_month: assert property (@(posedge clk) disable iff (rst)
    (edit.day >= DAY_MIN) && (edit.day <= month_days(edit.year, edit.month)))
    else $error("edited day outside month");

  // In idle no countdown is left over.
  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_IDLE) |-> (countdown == 14'd0))
    else $error("countdown left while idle");

endmodule
`default_nettype wire

FILE: rtl/crce_detent.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crce_detent: one encoder detent step
// Applies a single detent to the reminder length in idle mode or to the
// selected clock field in setup mode, with wrap-around and day clamping.
// ---------------------------------------------------------------------------
module crce_detent
  import crce_pkg::*;
(
  input  mode_t       mode,
  input  logic        positive,
  input  logic [7:0]  minutes,
  input  logic [7:0]  minutes_floor,
  input  logic [7:0]  minutes_ceiling,
  input  edit_t       edit_in,
  output logic [7:0]  minutes_next,
  output edit_t       edit_out
);

  logic        up;
  logic [11:0] year_step;
  logic [3:0]  month_step;
  logic [4:0]  days_cur;
  logic [4:0]  days_year;
  logic [4:0]  days_month;

  assign up = !positive;
  assign days_cur = month_days(edit_in.year, edit_in.month);

  always_comb begin
    if (up) begin
      year_step  = (edit_in.year >= YEAR_MAX) ? YEAR_MIN : edit_in.year + 12'd1;
      month_step = (edit_in.month >= MONTH_MAX) ? MONTH_MIN : edit_in.month + 4'd1;
    end else begin
      year_step  = (edit_in.year <= YEAR_MIN) ? YEAR_MAX : edit_in.year - 12'd1;
      month_step = (edit_in.month <= MONTH_MIN) ? MONTH_MAX : edit_in.month - 4'd1;
    end
  end

  assign days_year  = month_days(year_step, edit_in.month);
  assign days_month = month_days(edit_in.year, month_step);

  always_comb begin
    minutes_next = minutes;
    edit_out     = edit_in;
    case (mode)
      MODE_IDLE: begin
        if (positive) begin
          if (minutes > minutes_floor) minutes_next = minutes - 8'd1;
        end else begin
          if (minutes < minutes_ceiling) minutes_next = minutes + 8'd1;
        end
      end
      MODE_SETUP: begin
        case (edit_in.field)
          FIELD_YEAR: begin
            edit_out.year = year_step;
            if (edit_in.day > days_year) edit_out.day = days_year;
          end
          FIELD_MONTH: begin
            edit_out.month = month_step;
            if (edit_in.day > days_month) edit_out.day = days_month;
          end
          FIELD_DAY: begin
            if (up) begin
              edit_out.day = (edit_in.day >= days_cur) ? DAY_MIN : edit_in.day + 5'd1;
            end else begin
              edit_out.day = (edit_in.day <= DAY_MIN) ? days_cur : edit_in.day - 5'd1;
            end
          end
          FIELD_HOUR: begin
            if (up) begin
              edit_out.hour = (edit_in.hour >= HOUR_MAX) ? 5'd0 : edit_in.hour + 5'd1;
            end else begin
              edit_out.hour = (edit_in.hour == 5'd0) ? HOUR_MAX : edit_in.hour - 5'd1;
            end
          end
          FIELD_MINUTE: begin
            if (up) begin
              edit_out.minute = (edit_in.minute >= MINSEC_MAX) ? 6'd0
                                                               : edit_in.minute + 6'd1;
            end else begin
              edit_out.minute = (edit_in.minute == 6'd0) ? MINSEC_MAX
                                                         : edit_in.minute - 6'd1;
            end
          end
          FIELD_SECOND: begin
            if (up) begin
              edit_out.second = (edit_in.second >= MINSEC_MAX) ? 6'd0
                                                               : edit_in.second + 6'd1;
            end else begin
              edit_out.second = (edit_in.second == 6'd0) ? MINSEC_MAX
                                                         : edit_in.second - 6'd1;
            end
          end
          FIELD_CONFIRM: edit_out.save = !edit_in.save;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_countdown_reminder_with_clock_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_countdown_reminder_with_clock_editor: self-checking testbench
// Sends encoder, main key, setup key and one-second tick events into the
// reminder controller, keeps an independent prediction of its mode, minute
// setting, countdown and clock editor, and checks every output transaction
// field by field under random idling, a long output hold-off and several
// register settings.
// ----------------------------------------------------------------------------
module tb_countdown_reminder_with_clock_editor;
  import crce_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int IDLE_PERCENT    = 14;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int PHASE_EVENTS    = 300;

  typedef struct {
    req_t              kind;
    logic signed [6:0] change;
    logic              valid;
    logic [11:0]       year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } reminder_event_t;

  typedef struct {
    mode_t       mode;
    logic [7:0]  minutes;
    logic [13:0] left;
    field_t      field;
    logic        save;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        commit;
  } reminder_view_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        req_type;
  logic signed [6:0] encoder_change;
  logic              clock_valid;
  logic [11:0]       now_year;
  logic [3:0]        now_month;
  logic [4:0]        now_day;
  logic [4:0]        now_hour;
  logic [5:0]        now_minute;
  logic [5:0]        now_second;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        mode;
  logic [7:0]        reminder_minutes;
  logic [13:0]       seconds_left;
  logic [2:0]        edit_field;
  logic              choice_save;
  logic [11:0]       edit_year;
  logic [3:0]        edit_month;
  logic [4:0]        edit_day;
  logic [4:0]        edit_hour;
  logic [5:0]        edit_minute;
  logic [5:0]        edit_second;
  logic              commit_time;

  logic [7:0]  floor_min;
  logic [7:0]  ceiling_min;
  logic [2:0]  detent_size;
  mode_t       st_mode;
  logic [7:0]  st_minutes;
  logic [13:0] st_left;
  int          st_residue;
  field_t      st_field;
  logic        st_save;
  logic [11:0] st_year;
  logic [3:0]  st_month;
  logic [4:0]  st_day;
  logic [4:0]  st_hour;
  logic [5:0]  st_minute;
  logic [5:0]  st_second;

  reminder_view_t pending_views[$];
  int mismatches;
  int stall_hold;
  int quiet_cycles;
  bit calm;
  bit hold_request;

  countdown_reminder_with_clock_editor dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .encoder_change   (encoder_change),
    .clock_valid      (clock_valid),
    .now_year         (now_year),
    .now_month        (now_month),
    .now_day          (now_day),
    .now_hour         (now_hour),
    .now_minute       (now_minute),
    .now_second       (now_second),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mode             (mode),
    .reminder_minutes (reminder_minutes),
    .seconds_left     (seconds_left),
    .edit_field       (edit_field),
    .choice_save      (choice_save),
    .edit_year        (edit_year),
    .edit_month       (edit_month),
    .edit_day         (edit_day),
    .edit_hour        (edit_hour),
    .edit_minute      (edit_minute),
    .edit_second      (edit_second),
    .commit_time      (commit_time)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  function automatic int month_length(int y, int m);
    int len;
    case (m)
      2:           len = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int wrap_to(int v, bit up, int lo, int hi);
    if (up) return (v >= hi) ? lo : v + 1;
    return (v <= lo) ? hi : v - 1;
  endfunction

  function automatic void trim_day();
    int len;
    len = month_length(st_year, st_month);
    if (st_day > len) st_day = 5'(len);
  endfunction

  function automatic void edit_clock_field(bit up);
    case (st_field)
      FIELD_YEAR: begin
        st_year = 12'(wrap_to(st_year, up, YEAR_MIN, YEAR_MAX));
        trim_day();
      end
      FIELD_MONTH: begin
        st_month = 4'(wrap_to(st_month, up, MONTH_MIN, MONTH_MAX));
        trim_day();
      end
      FIELD_DAY:
        st_day = 5'(wrap_to(st_day, up, DAY_MIN, month_length(st_year, st_month)));
      FIELD_HOUR:   st_hour = 5'(wrap_to(st_hour, up, 0, HOUR_MAX));
      FIELD_MINUTE: st_minute = 6'(wrap_to(st_minute, up, 0, MINSEC_MAX));
      FIELD_SECOND: st_second = 6'(wrap_to(st_second, up, 0, MINSEC_MAX));
      default:      st_save = !st_save;
    endcase
  endfunction

  function automatic void apply_detent(bit positive);
    if (st_mode == MODE_IDLE) begin
      if (positive) begin
        if (st_minutes > floor_min) st_minutes = st_minutes - 8'd1;
      end else if (st_minutes < ceiling_min) begin
        st_minutes = st_minutes + 8'd1;
      end
    end else if (st_mode == MODE_SETUP) begin
      edit_clock_field(!positive);
    end
  endfunction

  function automatic void load_clock(reminder_event_t ev);
    if (ev.valid) begin
      st_year   = 12'(clamp_to(ev.year, YEAR_MIN, YEAR_MAX));
      st_month  = 4'(clamp_to(ev.month, MONTH_MIN, MONTH_MAX));
      st_day    = 5'(clamp_to(ev.day, DAY_MIN, month_length(st_year, st_month)));
      st_hour   = 5'(clamp_to(ev.hour, 0, HOUR_MAX));
      st_minute = 6'(clamp_to(ev.minute, 0, MINSEC_MAX));
      st_second = 6'(clamp_to(ev.second, 0, MINSEC_MAX));
    end else begin
      st_year   = YEAR_DEFAULT;
      st_month  = MONTH_MIN;
      st_day    = DAY_MIN;
      st_hour   = '0;
      st_minute = '0;
      st_second = '0;
    end
  endfunction

  function automatic reminder_view_t predict_event(reminder_event_t ev);
    reminder_view_t v;
    int detent_counts;
    logic commit;
    commit = 1'b0;
    case (ev.kind)
      REQ_ENCODER: begin
        detent_counts = (detent_size == 3'd0) ? 1 : int'(detent_size);
        st_residue += ev.change;
        while (st_residue >= detent_counts) begin
          apply_detent(1'b1);
          st_residue -= detent_counts;
        end
        while (st_residue <= -detent_counts) begin
          apply_detent(1'b0);
          st_residue += detent_counts;
        end
      end
      REQ_MAIN: begin
        if (st_mode == MODE_SETUP) begin
          if (st_field < FIELD_CONFIRM) begin
            st_field = field_t'(st_field + 3'd1);
          end else begin
            commit = st_save;
            st_mode = MODE_IDLE;
          end
        end else if (st_mode == MODE_IDLE) begin
          st_mode = MODE_COUNT;
          st_left = 14'(st_minutes * 60);
        end else begin
          st_mode = MODE_IDLE;
          st_left = '0;
        end
      end
      REQ_SETUP: begin
        if (st_mode == MODE_IDLE) begin
          st_mode = MODE_SETUP;
          load_clock(ev);
          st_field = FIELD_YEAR;
          st_save = 1'b1;
        end
      end
      default: begin
        if (st_mode == MODE_COUNT) begin
          if (st_left > 0) st_left = st_left - 14'd1;
          else st_mode = MODE_ALARM;
        end
      end
    endcase
    v.mode    = st_mode;
    v.minutes = st_minutes;
    v.left    = st_left;
    v.field   = st_field;
    v.save    = st_save;
    v.year    = st_year;
    v.month   = st_month;
    v.day     = st_day;
    v.hour    = st_hour;
    v.minute  = st_minute;
    v.second  = st_second;
    v.commit  = commit;
    return v;
  endfunction

  function automatic void reset_model();
    floor_min   = FLOOR_RESET;
    ceiling_min = CEILING_RESET;
    detent_size = DETENT_RESET;
    st_mode     = MODE_IDLE;
    st_minutes  = MINUTES_RESET;
    st_left     = '0;
    st_residue  = 0;
    st_field    = FIELD_YEAR;
    st_save     = 1'b1;
    st_year     = YEAR_DEFAULT;
    st_month    = MONTH_MIN;
    st_day      = DAY_MIN;
    st_hour     = '0;
    st_minute   = '0;
    st_second   = '0;
  endfunction

  function automatic reminder_event_t noise_event();
    reminder_event_t ev;
    ev.kind   = req_t'($urandom_range(3));
    ev.change = 7'($urandom);
    ev.valid  = 1'($urandom);
    ev.year   = 12'($urandom);
    ev.month  = 4'($urandom);
    ev.day    = 5'($urandom);
    ev.hour   = 5'($urandom);
    ev.minute = 6'($urandom);
    ev.second = 6'($urandom);
    return ev;
  endfunction

  function automatic reminder_event_t key_event(req_t kind);
    reminder_event_t ev;
    ev = noise_event();
    ev.kind = kind;
    return ev;
  endfunction

  function automatic reminder_event_t turn_event(int counts);
    reminder_event_t ev;
    ev = key_event(REQ_ENCODER);
    ev.change = 7'(counts);
    return ev;
  endfunction

  function automatic reminder_event_t setup_event(bit valid, int y, int m, int d,
                                                  int h, int mi, int s);
    reminder_event_t ev;
    ev = key_event(REQ_SETUP);
    ev.valid  = valid;
    ev.year   = 12'(y);
    ev.month  = 4'(m);
    ev.day    = 5'(d);
    ev.hour   = 5'(h);
    ev.minute = 6'(mi);
    ev.second = 6'(s);
    return ev;
  endfunction

  function automatic reminder_event_t random_setup_event();
    reminder_event_t ev;
    int y;
    int m;
    ev = key_event(REQ_SETUP);
    case ($urandom_range(9))
      0: ev.valid = 1'b0;
      1: ev.valid = 1'b1;
      2: ev = setup_event(1'b1, YEAR_MIN + 4 * $urandom_range(24), 2, 29,
                          $urandom_range(HOUR_MAX), $urandom_range(MINSEC_MAX),
                          $urandom_range(MINSEC_MAX));
      default: begin
        y = $urandom_range(YEAR_MAX, YEAR_MIN);
        m = $urandom_range(MONTH_MAX, MONTH_MIN);
        ev = setup_event(1'b1, y, m, $urandom_range(month_length(y, m), DAY_MIN),
                         $urandom_range(HOUR_MAX), $urandom_range(MINSEC_MAX),
                         $urandom_range(MINSEC_MAX));
      end
    endcase
    return ev;
  endfunction

  function automatic reminder_event_t random_turn();
    reminder_event_t ev;
    int d;
    int n;
    d = (detent_size == 3'd0) ? 1 : int'(detent_size);
    n = d * int'($urandom_range(3, 1)) + (($urandom_range(3) == 0) ? 1 : 0);
    if ($urandom_range(9) == 0) ev = key_event(REQ_ENCODER);
    else ev = turn_event($urandom_range(1) ? n : -n);
    return ev;
  endfunction

  // Stimulus follows the predicted mode so that most traffic forms complete
  // setup sessions and countdowns; a small share is unrelated noise.
  function automatic reminder_event_t pick_event();
    reminder_event_t ev;
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) begin
      ev = noise_event();
    end else begin
      case (st_mode)
        MODE_IDLE: begin
          if (roll < 40) ev = random_turn();
          else if (roll < 70) ev = random_setup_event();
          else if (roll < 95) ev = key_event(REQ_MAIN);
          else ev = key_event(REQ_TICK);
        end
        MODE_SETUP: begin
          if (roll < 60) ev = random_turn();
          else if (roll < 95) ev = key_event(REQ_MAIN);
          else ev = random_setup_event();
        end
        MODE_COUNT: begin
          if (roll < 96) ev = key_event(REQ_TICK);
          else if (roll < 98) ev = key_event(REQ_MAIN);
          else ev = random_turn();
        end
        default: begin
          if (roll < 50) ev = key_event(REQ_MAIN);
          else if (roll < 75) ev = key_event(REQ_TICK);
          else ev = random_turn();
        end
      endcase
    end
    return ev;
  endfunction

  task automatic send_event(input reminder_event_t ev);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= ev.kind;
    encoder_change <= ev.change;
    clock_valid    <= ev.valid;
    now_year       <= ev.year;
    now_month      <= ev.month;
    now_day        <= ev.day;
    now_hour       <= ev.hour;
    now_minute     <= ev.minute;
    now_second     <= ev.second;
    do @(posedge clk); while (in_stall);
    pending_views.push_back(predict_event(ev));
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] lo, input logic [7:0] hi,
                           input logic [2:0] counts);
    wait_idle(4);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FLOOR;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_CEILING;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_DETENT;
    cfg_data  <= {5'd0, counts};
    @(posedge clk);
    cfg_we <= 1'b0;
    floor_min   = lo;
    ceiling_min = hi;
    detent_size = counts;
  endtask

  task automatic bring_idle();
    while (st_mode != MODE_IDLE) send_event(key_event(REQ_MAIN));
  endtask

  task automatic test_directed_events();
    send_event(key_event(REQ_TICK));
    send_event(turn_event(63));
    send_event(turn_event(-64));
    send_event(setup_event(1'b1, 4095, 15, 31, 31, 63, 63));
    send_event(key_event(REQ_SETUP));
    send_event(key_event(REQ_TICK));
    // The residue left over from idle completes this detent.
    send_event(turn_event(-1));
    send_event(key_event(REQ_MAIN));
    send_event(turn_event(2));
    send_event(key_event(REQ_MAIN));
    send_event(turn_event(-2));
    repeat (3) begin
      send_event(key_event(REQ_MAIN));
      send_event(turn_event(-2));
    end
    send_event(key_event(REQ_MAIN));
    send_event(turn_event(-2));
    send_event(key_event(REQ_MAIN));
    send_event(setup_event(1'b0, 4095, 15, 31, 31, 63, 63));
    repeat (7) send_event(key_event(REQ_MAIN));
    send_event(key_event(REQ_MAIN));
    send_event(key_event(REQ_TICK));
    send_event(key_event(REQ_MAIN));
  endtask

  task automatic test_minute_limits();
    bring_idle();
    configure(8'd1, 8'd255, 3'd0);
    repeat (4) send_event(turn_event(-64));
    send_event(key_event(REQ_MAIN));
    send_event(key_event(REQ_TICK));
    send_event(key_event(REQ_MAIN));
    // Floor above ceiling: only the floor guard can move the setting.
    configure(8'd200, 8'd100, 3'd4);
    send_event(turn_event(-64));
    repeat (4) send_event(turn_event(63));
  endtask

  task automatic test_alarm();
    bring_idle();
    configure(8'd1, 8'd255, 3'd1);
    repeat (5) send_event(turn_event(63));
    send_event(key_event(REQ_MAIN));
    repeat (62) send_event(key_event(REQ_TICK));
    send_event(key_event(REQ_SETUP));
    send_event(turn_event(5));
    send_event(key_event(REQ_MAIN));
  endtask

  task automatic test_backpressure();
    wait_idle(4);
    calm = 1'b1;
    hold_request = 1'b1;
    repeat (30) send_event(pick_event());
    calm = 1'b0;
    wait_idle(4);
  endtask

  task automatic random_run(input int count);
    repeat (count) send_event(pick_event());
  endtask

  task automatic test_random_traffic();
    configure(FLOOR_RESET, CEILING_RESET, DETENT_RESET);
    random_run(PHASE_EVENTS);
    configure(8'd1, 8'd255, 3'd1);
    random_run(PHASE_EVENTS);
    calm = 1'b1;
    configure(8'd1, 8'd2, 3'd0);
    random_run(PHASE_EVENTS);
    calm = 1'b0;
    configure(8'd255, 8'd1, 3'd4);
    random_run(PHASE_EVENTS);
    configure(8'd30, 8'd40, 3'd3);
    random_run(PHASE_EVENTS);
    configure(8'd1, 8'd255, 3'd7);
    random_run(PHASE_EVENTS);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    reminder_view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $error("output transaction with no expected result waiting");
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        check_field("mode", want.mode, mode);
        check_field("reminder_minutes", want.minutes, reminder_minutes);
        check_field("seconds_left", want.left, seconds_left);
        check_field("edit_field", want.field, edit_field);
        check_field("choice_save", want.save, choice_save);
        check_field("edit_year", want.year, edit_year);
        check_field("edit_month", want.month, edit_month);
        check_field("edit_day", want.day, edit_day);
        check_field("edit_hour", want.hour, edit_hour);
        check_field("edit_minute", want.minute, edit_minute);
        check_field("edit_second", want.second, edit_second);
        check_field("commit_time", want.commit, commit_time);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_hold = HOLD_OFF_CYCLES;
    end
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FLOOR;
    cfg_data       = '0;
    in_valid       = 1'b0;
    req_type       = REQ_ENCODER;
    encoder_change = '0;
    clock_valid    = 1'b0;
    now_year       = YEAR_DEFAULT;
    now_month      = MONTH_MIN;
    now_day        = DAY_MIN;
    now_hour       = '0;
    now_minute     = '0;
    now_second     = '0;
    out_stall      = 1'b0;
    mismatches     = 0;
    stall_hold     = 0;
    quiet_cycles   = 0;
    calm           = 1'b0;
    hold_request   = 1'b0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_events();
    test_minute_limits();
    test_alarm();
    test_backpressure();
    test_random_traffic();
    wait_idle(SETTLE_CYCLES);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
